// ----- hdl/sccp_pkg.sv -----
// ----------------------------------------------------------------------------
// sccp_pkg
// shared constants, types and helpers for the sine/cosine polynomial unit
// ----------------------------------------------------------------------------
package sccp_pkg;

    // angle constants with 60 fraction bits
    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [63:0] HALF_PI_Q60 = 64'h1921FB54442D1846;
    localparam logic [63:0] TWO_PI_Q60  = 64'h6487ED5110B4611A;

    // polynomial coefficients, unsigned q31
    localparam logic [31:0] ONE_Q31      = 32'd2147483648;
    localparam logic [31:0] HALF_Q31     = 32'd1073741824;
    localparam logic [31:0] INV6_Q31     = 32'd357913941;
    localparam logic [31:0] INV120_Q31   = 32'd17895697;
    localparam logic [31:0] INV5040_Q31  = 32'd426088;
    localparam logic [31:0] INV24_Q31    = 32'd89478485;
    localparam logic [31:0] INV720_Q31   = 32'd2982616;
    localparam logic [31:0] INV40320_Q31 = 32'd53261;

    // number of pipeline stages in the polynomial and output section
    localparam int POLY_STAGES = 12;

    // octant fold decisions carried from reduction to polynomial
    typedef struct packed {
        logic sneg;   // angle was past a half turn
        logic swap;   // angle was past a quarter turn inside the half turn
    } sccp_fold_t;

    // round half up a q62 product back to q31
    function automatic logic [32:0] rnd_q31(input logic [63:0] prod);
        logic [63:0] s;
        s = prod + 64'h0000_0000_4000_0000;
        return s[63:31];
    endfunction

endpackage

// ----- hdl/sccp_reduce.sv -----
// ----------------------------------------------------------------------------
// sccp_reduce
// pipelined range reduction of the angle into 0 to pi/2 with fold flags
// ----------------------------------------------------------------------------
module sccp_reduce #(
    parameter int ANGLE_FRAC_BITS = 28
) (
    input  logic                         clk,
    input  logic [33-ANGLE_FRAC_BITS:0]  en,
    input  logic signed [31:0]           angle,
    output logic [31:0]                  r,
    output sccp_pkg::sccp_fold_t         fold
);

    localparam int QB  = 29 - ANGLE_FRAC_BITS;   // quotient bits of angle / 2pi
    localparam int SH  = 32 - ANGLE_FRAC_BITS;   // 60-bit constants to work scale
    localparam int SH2 = ANGLE_FRAC_BITS - 3;    // work scale to q31
    localparam int XW  = ANGLE_FRAC_BITS + 31;   // reduced angle width
    localparam int RW  = 60;                     // remainder width

    localparam logic [63:0] TWO_W  = (sccp_pkg::TWO_PI_Q60 + (64'd1 << (SH - 1))) >> SH;
    localparam logic [63:0] PI_W   = (sccp_pkg::PI_Q60 + (64'd1 << (SH - 1))) >> SH;
    localparam logic [63:0] HALF_W = (sccp_pkg::HALF_PI_Q60 + (64'd1 << (SH - 1))) >> SH;

    localparam logic [XW-1:0] TWO_X  = TWO_W[XW-1:0];
    localparam logic [XW-1:0] PI_X   = PI_W[XW-1:0];
    localparam logic [XW-1:0] HALF_X = HALF_W[XW-1:0];
    localparam logic [XW:0]   RND_X  = (XW + 1)'(1) << (SH2 - 1);

    logic [RW-1:0] rem_reg [0:QB];
    logic          neg_reg [0:QB];
    logic          nz_reg  [0:QB];

    logic [31:0]   mag;
    logic [XW-1:0] rem_low;
    logic          rem_zero;
    logic [XW-1:0] x_reg;
    logic [XW-1:0] xs_reg;
    logic          sneg_reg;
    logic [XW-1:0] d_reg;
    logic          sneg_d_reg;
    logic          swap_reg;
    logic [XW:0]   d_rnd;
    logic [31:0]   r_reg;
    sccp_pkg::sccp_fold_t fold_reg;

    // magnitude of the angle, -2^31 maps to 2^31
    assign mag = angle[31] ? (~angle + 32'd1) : angle;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= {mag, 28'd0};
            neg_reg[0] <= angle[31];
            nz_reg[0]  <= |angle;
        end
    end

    // restoring remainder by 2pi, one quotient bit per stage
    for (genvar j = 1; j <= QB; j++)
    begin : g_rem
        localparam logic [RW-1:0] DIV = RW'(TWO_W << (QB - j));

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= (rem_reg[j-1] >= DIV) ? (rem_reg[j-1] - DIV) : rem_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                nz_reg[j]  <= nz_reg[j-1];
            end
        end
    end

    assign rem_low  = rem_reg[QB][XW-1:0];
    assign rem_zero = (rem_reg[QB] == '0);

    // map remainder to 0..2pi, positive multiples stay at 2pi
    always_ff @(posedge clk)
    begin
        if (en[QB+1])
        begin
            if (neg_reg[QB])
                x_reg <= rem_zero ? '0 : (TWO_X - rem_low);
            else
                x_reg <= (rem_zero && nz_reg[QB]) ? TWO_X : rem_low;
        end
    end

    // half turn fold
    always_ff @(posedge clk)
    begin
        if (en[QB+2])
        begin
            sneg_reg <= (x_reg > PI_X);
            xs_reg   <= (x_reg > PI_X) ? (x_reg - PI_X) : x_reg;
        end
    end

    // quarter turn fold
    always_ff @(posedge clk)
    begin
        if (en[QB+3])
        begin
            sneg_d_reg <= sneg_reg;
            swap_reg   <= (xs_reg > HALF_X);
            d_reg      <= (xs_reg > HALF_X) ? (xs_reg - HALF_X) : xs_reg;
        end
    end

    // round to unsigned q31
    assign d_rnd = {1'b0, d_reg} + RND_X;

    always_ff @(posedge clk)
    begin
        if (en[QB+4])
        begin
            r_reg         <= d_rnd[SH2+31:SH2];
            fold_reg.sneg <= sneg_d_reg;
            fold_reg.swap <= swap_reg;
        end
    end

    assign r    = r_reg;
    assign fold = fold_reg;

endmodule

// ----- hdl/sccp_poly.sv -----
// ----------------------------------------------------------------------------
// sccp_poly
// pipelined horner evaluation of sine and cosine plus output formatting
// ----------------------------------------------------------------------------
module sccp_poly #(
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic                                clk,
    input  logic [sccp_pkg::POLY_STAGES-1:0]    en,
    input  logic [31:0]                         r,
    input  sccp_pkg::sccp_fold_t                fold,
    output logic signed [31:0]                  sine_value,
    output logic signed [31:0]                  cosine_value
);

    localparam int SH3 = 31 - RESULT_FRAC_BITS;
    localparam logic [32:0] LIM = 33'd1 << RESULT_FRAC_BITS;
    localparam logic [33:0] RND = 34'd1 << (SH3 - 1);

    // stage 1
    logic [31:0] r1_reg;
    logic [63:0] prr1_reg;
    sccp_pkg::sccp_fold_t f1_reg;
    // stage 2
    logic [31:0] r2_reg;
    logic [32:0] x2_2_reg;
    sccp_pkg::sccp_fold_t f2_reg;
    // stages 3 to 9
    logic [31:0] r3_reg, r4_reg, r5_reg, r6_reg, r7_reg, r8_reg;
    logic [32:0] x2_3_reg, x2_4_reg, x2_5_reg, x2_6_reg, x2_7_reg, x2_8_reg;
    sccp_pkg::sccp_fold_t f3_reg, f4_reg, f5_reg, f6_reg, f7_reg, f8_reg, f9_reg;
    logic [63:0] ms3_reg, mc3_reg, ms5_reg, mc5_reg, ms7_reg, mc7_reg, ms9_reg, mc9_reg;
    logic [31:0] ps4_reg, pc4_reg, ps6_reg, pc6_reg, ps8_reg, pc8_reg;
    // stage 10
    logic [33:0] sv_c, cv_c;
    logic signed [33:0] s10_reg, c10_reg;
    logic sneg10_reg, cneg10_reg;
    // stage 11
    logic [33:0] smag_c, cmag_c, srnd_c, crnd_c;
    logic [32:0] sm11_reg, cm11_reg;
    logic sneg11_reg, cneg11_reg;
    // stage 12
    logic [32:0] ssat_c, csat_c;
    logic signed [31:0] sine_reg, cosine_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r1_reg   <= r;
            f1_reg   <= fold;
            prr1_reg <= 64'(r) * 64'(r);
        end
        if (en[1])
        begin
            r2_reg   <= r1_reg;
            f2_reg   <= f1_reg;
            x2_2_reg <= sccp_pkg::rnd_q31(prr1_reg);
        end
        if (en[2])
        begin
            r3_reg   <= r2_reg;
            f3_reg   <= f2_reg;
            x2_3_reg <= x2_2_reg;
            ms3_reg  <= 64'(x2_2_reg) * 64'(sccp_pkg::INV5040_Q31);
            mc3_reg  <= 64'(x2_2_reg) * 64'(sccp_pkg::INV40320_Q31);
        end
        if (en[3])
        begin
            r4_reg   <= r3_reg;
            f4_reg   <= f3_reg;
            x2_4_reg <= x2_3_reg;
            ps4_reg  <= sccp_pkg::INV120_Q31 - 32'(sccp_pkg::rnd_q31(ms3_reg));
            pc4_reg  <= sccp_pkg::INV720_Q31 - 32'(sccp_pkg::rnd_q31(mc3_reg));
        end
        if (en[4])
        begin
            r5_reg   <= r4_reg;
            f5_reg   <= f4_reg;
            x2_5_reg <= x2_4_reg;
            ms5_reg  <= 64'(x2_4_reg) * 64'(ps4_reg);
            mc5_reg  <= 64'(x2_4_reg) * 64'(pc4_reg);
        end
        if (en[5])
        begin
            r6_reg   <= r5_reg;
            f6_reg   <= f5_reg;
            x2_6_reg <= x2_5_reg;
            ps6_reg  <= sccp_pkg::INV6_Q31 - 32'(sccp_pkg::rnd_q31(ms5_reg));
            pc6_reg  <= sccp_pkg::INV24_Q31 - 32'(sccp_pkg::rnd_q31(mc5_reg));
        end
        if (en[6])
        begin
            r7_reg   <= r6_reg;
            f7_reg   <= f6_reg;
            x2_7_reg <= x2_6_reg;
            ms7_reg  <= 64'(x2_6_reg) * 64'(ps6_reg);
            mc7_reg  <= 64'(x2_6_reg) * 64'(pc6_reg);
        end
        if (en[7])
        begin
            r8_reg   <= r7_reg;
            f8_reg   <= f7_reg;
            x2_8_reg <= x2_7_reg;
            ps8_reg  <= sccp_pkg::ONE_Q31 - 32'(sccp_pkg::rnd_q31(ms7_reg));
            pc8_reg  <= sccp_pkg::HALF_Q31 - 32'(sccp_pkg::rnd_q31(mc7_reg));
        end
        if (en[8])
        begin
            f9_reg  <= f8_reg;
            ms9_reg <= 64'(r8_reg) * 64'(ps8_reg);
            mc9_reg <= 64'(x2_8_reg) * 64'(pc8_reg);
        end
    end

    // final horner step, cosine kept signed since it may dip below zero
    assign sv_c = {1'b0, sccp_pkg::rnd_q31(ms9_reg)};
    assign cv_c = {2'b0, sccp_pkg::ONE_Q31} - {1'b0, sccp_pkg::rnd_q31(mc9_reg)};

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s10_reg    <= f9_reg.swap ? $signed(cv_c) : $signed(sv_c);
            c10_reg    <= f9_reg.swap ? $signed(sv_c) : $signed(cv_c);
            sneg10_reg <= f9_reg.sneg;
            cneg10_reg <= f9_reg.sneg ^ f9_reg.swap;
        end
    end

    // magnitude and round half away from zero
    assign smag_c = s10_reg[33] ? 34'(-s10_reg) : 34'(s10_reg);
    assign cmag_c = c10_reg[33] ? 34'(-c10_reg) : 34'(c10_reg);
    assign srnd_c = (smag_c + RND) >> SH3;
    assign crnd_c = (cmag_c + RND) >> SH3;

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            sm11_reg   <= srnd_c[32:0];
            cm11_reg   <= crnd_c[32:0];
            sneg11_reg <= sneg10_reg ^ s10_reg[33];
            cneg11_reg <= cneg10_reg ^ c10_reg[33];
        end
    end

    // saturate to one and apply sign
    assign ssat_c = (sm11_reg > LIM) ? LIM : sm11_reg;
    assign csat_c = (cm11_reg > LIM) ? LIM : cm11_reg;

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            sine_reg   <= sneg11_reg ? -$signed(ssat_c[31:0]) : $signed(ssat_c[31:0]);
            cosine_reg <= cneg11_reg ? -$signed(csat_c[31:0]) : $signed(csat_c[31:0]);
        end
    end

    assign sine_value   = sine_reg;
    assign cosine_value = cosine_reg;

endmodule

// ----- hdl/sine_cosine_polynomial_unit_top.sv -----
// ----------------------------------------------------------------------------
// sine_cosine_polynomial_unit_top
// fixed-point sine and cosine of an angle by range reduction and taylor series
// ----------------------------------------------------------------------------
// takes one signed angle in radians (ANGLE_FRAC_BITS fraction bits, q3.28 by
// default) per transaction and returns its sine and cosine together as signed
// q1.RESULT_FRAC_BITS, saturated to plus or minus one. the unit is a single
// pipeline that accepts a new angle every clock unless a stalled result has
// backed it up to the input. the reduction by 2pi takes one compare-subtract
// stage per quotient bit, so smaller ANGLE_FRAC_BITS (larger angle range)
// adds stages; the polynomial section is a fixed 12 stages: a squaring
// multiply, a rounding step, multiplier-pair and round/subtract stages in
// turn, then swap, rounding and saturation. each stage holds its item while
// the stage after it is full and stalled, so bubbles collapse and a waiting
// result does not block new angles until the pipeline is actually full.
// ----------------------------------------------------------------------------
module sine_cosine_polynomial_unit_top #(
    parameter int ANGLE_FRAC_BITS  = 28,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic               clk,
    input  logic               rst_n,
    // angle channel
    input  logic               angle_valid,
    output logic               angle_ready,
    input  logic signed [31:0] angle,
    // result channel
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [31:0] sine_value,
    output logic signed [31:0] cosine_value
);

    // stage counts: reduction has one input stage, one stage per quotient bit,
    // then fix-up, half-turn fold, quarter-turn fold and rounding to q31
    localparam int RED_STAGES = (29 - ANGLE_FRAC_BITS) + 5;
    localparam int N          = RED_STAGES + sccp_pkg::POLY_STAGES;

    logic [N-1:0] v_reg;
    logic [N-1:0] v_next;
    logic [N-1:0] v_shift;
    logic [N:0]   en;

    logic [31:0]          r;
    sccp_pkg::sccp_fold_t fold;

    // a stage may load when it is empty or when its successor moves on
    assign en[N] = result_ready;

    for (genvar k = 0; k < N; k++)
    begin : g_en
        assign en[k] = ~v_reg[k] | en[k+1];
    end

    // valid bits move along with the data of each stage
    assign v_shift = {v_reg[N-2:0], angle_valid};
    assign v_next  = (en[N-1:0] & v_shift) | (~en[N-1:0] & v_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign angle_ready  = en[0];
    assign result_valid = v_reg[N-1];

    // range reduction into 0..pi/2 with octant flags
    sccp_reduce #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_reduce (
        .clk   (clk),
        .en    (en[RED_STAGES-1:0]),
        .angle (angle),
        .r     (r),
        .fold  (fold)
    );

    // horner polynomials, swap, rounding and saturation
    sccp_poly #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_poly (
        .clk          (clk),
        .en           (en[N-1:RED_STAGES]),
        .r            (r),
        .fold         (fold),
        .sine_value   (sine_value),
        .cosine_value (cosine_value)
    );

endmodule
